### rtl/sls_pkg.sv
// Package for the signal level statistics block.
// Holds request and selection codes, the metric set type, shared constants and a saturating add.
// Has no dependencies.
package sls_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int RMS_FRACTION_BITS_DEF = 8;
	localparam int TOTAL_BITS = 64;
	localparam int VALUE_BITS = 16;
	localparam int RMS_BITS = 24;

	typedef enum logic [2:0] {
		REQ_ADD   = 3'd0,
		REQ_OPEN  = 3'd1,
		REQ_CLOSE = 3'd2,
		REQ_READ  = 3'd3,
		REQ_CLEAR = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		SEL_SESSION = 2'd0,
		SEL_RECENT  = 2'd1,
		SEL_SPAN    = 2'd2,
		SEL_NONE    = 2'd3
	} sel_t;

	typedef struct packed {
		logic [TOTAL_BITS-1:0] count;
		logic [TOTAL_BITS-1:0] clip_lo;
		logic [TOTAL_BITS-1:0] clip_hi;
		logic [TOTAL_BITS-1:0] sq_sum;
		logic [VALUE_BITS-1:0] mn;
		logic [VALUE_BITS-1:0] mx;
	} set_t;

	function automatic logic [TOTAL_BITS-1:0] sat_add(input logic [TOTAL_BITS-1:0] a,
		input logic [TOTAL_BITS-1:0] b);
		logic [TOTAL_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : s[TOTAL_BITS-1:0];
	endfunction

endpackage

### rtl/signal_level_statistics.sv
// Top level of the signal level statistics block.
// Depends on sls_pkg for codes, the set type and the saturating add.
//
// The block keeps three metric sets (session, recent tally, capture span) and
// answers every request with one result holding the metrics of the selected
// set after the request has taken effect. A request is taken only while the
// block is idle; it is then answered in these steps: the request is applied,
// the selected set is read out, a restoring division of the scaled square sum
// by the count runs, a digit-by-digit square root follows, and the result is
// presented. Division and square root share a single 65-bit
// subtract-and-compare unit. When the selected count is zero the arithmetic
// steps are skipped. The result stays on the outputs until it is taken, and
// the next request is accepted in the cycle after that. RMS is unsigned fixed
// point with RMS_FRACTION_BITS fraction bits, saturated to 24 bits; all totals
// saturate rather than wrap.
module signal_level_statistics
	import sls_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int RMS_FRACTION_BITS = RMS_FRACTION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            req_type,
	input  logic [1:0]            set_select,
	input  logic [31:0]           tally_count,
	input  logic [15:0]           tally_minimum,
	input  logic [15:0]           tally_maximum,
	input  logic [31:0]           tally_clip_low,
	input  logic [31:0]           tally_clip_high,
	input  logic [63:0]           tally_square_sum,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           total_count,
	output logic [15:0]           lowest_value,
	output logic [15:0]           highest_value,
	output logic [63:0]           low_clips,
	output logic [63:0]           high_clips,
	output logic [RMS_BITS-1:0]   rms_level,
	output logic                  span_active
);

	localparam int DIV_BITS = 2 * TOTAL_BITS;
	localparam int SHIFT = 2 * RMS_FRACTION_BITS;
	localparam int SQ_BITS = 2 * RMS_BITS;
	localparam int DIV_STEPS = DIV_BITS;
	localparam int SQRT_STEPS = RMS_BITS;
	localparam int STEP_BITS = $clog2(DIV_STEPS + 1);
	localparam logic [VALUE_BITS-1:0] SAMPLE_MASK =
		VALUE_BITS'((32'd1 << SAMPLE_BITS) - 32'd1);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_APPLY = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_SQRT  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	set_t session_q, recent_q, span_q;
	set_t tally_q, clear_set, session_fold, span_fold, sel_set;
	logic span_open_q;
	req_t req_q;
	sel_t sel_q;
	logic [STEP_BITS-1:0] step_q;

	// Division and square root operands.
	logic [DIV_BITS-1:0]   dvd_q;
	logic [TOTAL_BITS-1:0] rem_q;
	logic [TOTAL_BITS-1:0] dvs_q;
	logic [SQ_BITS-1:0]    op_q, root_q, one_q;
	logic                  sat_q;

	// Shared subtract-and-compare unit.
	logic [TOTAL_BITS:0]   sub_a, sub_b;
	logic [TOTAL_BITS+1:0] sub_d;
	logic                  sub_ge;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);

	always_comb begin
		clear_set = '0;
		clear_set.mn = SAMPLE_MASK;
	end

	function automatic set_t fold(input set_t acc, input set_t t);
		set_t r;
		r.count   = sat_add(acc.count, t.count);
		r.clip_lo = sat_add(acc.clip_lo, t.clip_lo);
		r.clip_hi = sat_add(acc.clip_hi, t.clip_hi);
		r.sq_sum  = sat_add(acc.sq_sum, t.sq_sum);
		r.mn = (t.mn < acc.mn) ? t.mn : acc.mn;
		r.mx = (t.mx > acc.mx) ? t.mx : acc.mx;
		return r;
	endfunction

	assign session_fold = fold(session_q, tally_q);
	assign span_fold    = fold(span_q, tally_q);

	always_comb begin
		unique case (sel_q)
			SEL_SESSION: sel_set = session_q;
			SEL_RECENT:  sel_set = recent_q;
			SEL_SPAN:    sel_set = span_q;
			default:     sel_set = '0;
		endcase
	end

	// During division the partial remainder with the next dividend bit is
	// compared against the count; during the square root the remaining
	// operand is compared against the trial root.
	always_comb begin
		if (state_q == ST_DIV) begin
			sub_a = {rem_q, dvd_q[DIV_BITS-1]};
			sub_b = {1'b0, dvs_q};
		end else begin
			sub_a = (TOTAL_BITS+1)'(op_q);
			sub_b = (TOTAL_BITS+1)'(root_q | one_q);
		end
		sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
		sub_ge = !sub_d[TOTAL_BITS+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			session_q   <= clear_set;
			recent_q    <= clear_set;
			span_q      <= clear_set;
			span_open_q <= 1'b0;
			step_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					unique case (req_q)
						REQ_ADD: begin
							if (tally_q.count != '0) begin
								session_q <= session_fold;
								recent_q  <= tally_q;
								if (span_open_q) span_q <= span_fold;
							end
						end
						REQ_OPEN: begin
							span_q      <= clear_set;
							span_open_q <= 1'b1;
						end
						REQ_CLOSE: span_open_q <= 1'b0;
						REQ_CLEAR: begin
							session_q   <= clear_set;
							recent_q    <= clear_set;
							span_q      <= clear_set;
							span_open_q <= 1'b0;
						end
						default: ;
					endcase
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= (sel_set.count == '0) ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_BITS'(SQRT_STEPS - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture, output registers and the arithmetic datapath.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_q           <= (req_type > 3'(REQ_CLEAR)) ? REQ_READ : req_t'(req_type);
			sel_q           <= sel_t'(set_select);
			tally_q.count   <= TOTAL_BITS'(tally_count);
			tally_q.clip_lo <= TOTAL_BITS'(tally_clip_low);
			tally_q.clip_hi <= TOTAL_BITS'(tally_clip_high);
			tally_q.sq_sum  <= tally_square_sum;
			tally_q.mn      <= tally_minimum & SAMPLE_MASK;
			tally_q.mx      <= tally_maximum & SAMPLE_MASK;
		end
		if (state_q == ST_LOAD) begin
			total_count   <= sel_set.count;
			lowest_value  <= (sel_set.count == '0) ? '0 : sel_set.mn;
			highest_value <= sel_set.mx;
			low_clips     <= sel_set.clip_lo;
			high_clips    <= sel_set.clip_hi;
			span_active   <= span_open_q;
			rms_level     <= '0;
			dvd_q <= {{TOTAL_BITS{1'b0}}, sel_set.sq_sum} << SHIFT;
			rem_q <= '0;
			dvs_q <= sel_set.count;
		end
		if (state_q == ST_DIV) begin
			// The quotient bits shift in where the dividend bits leave.
			dvd_q <= {dvd_q[DIV_BITS-2:0], sub_ge};
			rem_q <= sub_ge ? sub_d[TOTAL_BITS-1:0] : sub_a[TOTAL_BITS-1:0];
			if (step_q == STEP_BITS'(DIV_STEPS - 1)) begin
				// A quotient at or beyond 2^48 has a root that fills all 24 bits.
				sat_q  <= (dvd_q[DIV_BITS-2:SQ_BITS-1] != '0);
				op_q   <= {dvd_q[SQ_BITS-2:0], sub_ge};
				root_q <= '0;
				one_q  <= SQ_BITS'(1) << (SQ_BITS - 2);
			end
		end
		if (state_q == ST_SQRT) begin
			if (sub_ge) begin
				op_q   <= sub_d[SQ_BITS-1:0];
				root_q <= (root_q >> 1) | one_q;
			end else begin
				root_q <= root_q >> 1;
			end
			one_q <= one_q >> 2;
			if (step_q == STEP_BITS'(SQRT_STEPS - 1)) begin
				rms_level <= sat_q ? {RMS_BITS{1'b1}} :
					(sub_ge ? RMS_BITS'((root_q >> 1) | one_q) : RMS_BITS'(root_q >> 1));
			end
		end
	end

`ifndef ASSERT_OFF
	// No second request may be taken while one is being worked on.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// A waiting result holds its computed RMS value.
	a_rms_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rms_level))
		else $error("rms changed while result waits");

	// An empty set reports a zero minimum and a zero RMS.
	a_empty_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_count == '0 |-> lowest_value == '0 && rms_level == '0)
		else $error("empty set reports nonzero minimum or rms");
`endif

endmodule

### tb/sv/signal_level_statistics_test.sv
// Self-checking testbench for the signal level statistics block.
// Depends on sls_pkg and the signal_level_statistics RTL; needs no files or arguments.
// A metrics predictor in a small scoreboard class checks every result field by field.
module signal_level_statistics_test
	import sls_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// One expected answer of the block.
	typedef struct {
		logic [63:0] count;
		logic [15:0] lowest;
		logic [15:0] highest;
		logic [63:0] clip_lo;
		logic [63:0] clip_hi;
		logic [23:0] rms;
		logic        active;
	} metrics_t;

	// Scoreboard: keeps its own copy of the three metric sets and a queue of answers.
	class metrics_board;
		set_t        sets[3];
		bit          span_on;
		metrics_t    pending[$];
		int          errors;
		int          checked;

		function void clear_one(int k);
			sets[k] = '0;
			sets[k].mn = 16'hFFFF;
		endfunction

		function void clear_all();
			for (int k = 0; k < 3; k++) clear_one(k);
			span_on = 0;
		endfunction

		function new();
			clear_all();
			errors = 0;
			checked = 0;
		endfunction

		function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? '1 : s[63:0];
		endfunction

		function void merge(int k, set_t t);
			sets[k].count = add_sat(sets[k].count, t.count);
			sets[k].clip_lo = add_sat(sets[k].clip_lo, t.clip_lo);
			sets[k].clip_hi = add_sat(sets[k].clip_hi, t.clip_hi);
			sets[k].sq_sum = add_sat(sets[k].sq_sum, t.sq_sum);
			if (t.mn < sets[k].mn) sets[k].mn = t.mn;
			if (t.mx > sets[k].mx) sets[k].mx = t.mx;
		endfunction

		// Root mean square scaled by 2^8: floor(sqrt(sum * 2^16 / count)), 24 bits.
		function logic [23:0] rms_of(logic [63:0] sum, logic [63:0] count);
			logic [127:0] quotient;
			logic [23:0]  root;
			logic [47:0]  trial;
			if (count == 0) return '0;
			quotient = {48'd0, sum, 16'd0} / {64'd0, count};
			root = '0;
			for (int i = 23; i >= 0; i--) begin
				trial = {24'd0, root | (24'd1 << i)};
				if (quotient[127:48] != 0 || trial * trial <= quotient) root[i] = 1'b1;
			end
			return root;
		endfunction

		// Note an accepted request and queue its expected answer.
		function void note_request(logic [2:0] req, logic [1:0] sel, set_t t);
			metrics_t m;
			set_t     s;
			case (req)
				REQ_ADD: if (t.count != 0) begin
					merge(SEL_SESSION, t);
					sets[SEL_RECENT] = t;
					if (span_on) merge(SEL_SPAN, t);
				end
				REQ_OPEN: begin
					clear_one(SEL_SPAN);
					span_on = 1;
				end
				REQ_CLOSE: span_on = 0;
				REQ_CLEAR: clear_all();
				default: ;
			endcase
			m = '{default: '0};
			if (sel != SEL_NONE) begin
				s = sets[sel];
				m.count = s.count;
				m.lowest = (s.count == 0) ? 16'd0 : s.mn;
				m.highest = s.mx;
				m.clip_lo = s.clip_lo;
				m.clip_hi = s.clip_hi;
				m.rms = rms_of(s.sq_sum, s.count);
			end
			m.active = span_on;
			pending.push_back(m);
		endfunction

		// Compare one accepted answer with the oldest expectation.
		function void check_answer(metrics_t got);
			metrics_t want;
			if (pending.size() == 0) begin
				$error("answer with no request outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.count !== want.count) begin
				$error("total_count: expected %0d, got %0d", want.count, got.count); errors++;
			end
			if (got.lowest !== want.lowest) begin
				$error("lowest_value: expected %0d, got %0d", want.lowest, got.lowest); errors++;
			end
			if (got.highest !== want.highest) begin
				$error("highest_value: expected %0d, got %0d", want.highest, got.highest);
				errors++;
			end
			if (got.clip_lo !== want.clip_lo) begin
				$error("low_clips: expected %0d, got %0d", want.clip_lo, got.clip_lo); errors++;
			end
			if (got.clip_hi !== want.clip_hi) begin
				$error("high_clips: expected %0d, got %0d", want.clip_hi, got.clip_hi); errors++;
			end
			if (got.rms !== want.rms) begin
				$error("rms_level: expected %0d, got %0d", want.rms, got.rms); errors++;
			end
			if (got.active !== want.active) begin
				$error("span_active: expected %0d, got %0d", want.active, got.active); errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  req_type = '0;
	logic [1:0]  set_select = '0;
	logic [31:0] tally_count = '0;
	logic [15:0] tally_minimum = '0;
	logic [15:0] tally_maximum = '0;
	logic [31:0] tally_clip_low = '0;
	logic [31:0] tally_clip_high = '0;
	logic [63:0] tally_square_sum = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [63:0] total_count;
	logic [15:0] lowest_value;
	logic [15:0] highest_value;
	logic [63:0] low_clips;
	logic [63:0] high_clips;
	logic [23:0] rms_level;
	logic        span_active;

	metrics_board board = new();
	int          sent = 0;
	longint      cycles = 0;
	// Hard limit on the run, far above what the requests plus receiver stalls need.
	localparam longint CYCLE_LIMIT = 1500000;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	signal_level_statistics dut (.*);

	// Cycle counter with a hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycles,
				board.pending.size());
			$display("signal_level_statistics_test: done, errors");
			$finish;
		end
	end

	// Receiver: stalls in a pattern whose duty mode is drawn anew at random,
	// with some windows fully open so that answers are also taken at once.
	int stall_mode = 0;
	always @(posedge clk) begin
		if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= (cycles % 3) != 0;
			2: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= (cycles % 7) == 0;
		endcase
	end

	// Monitor: every answer taken at a clock edge goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_answer('{total_count, lowest_value, highest_value, low_clips,
				high_clips, rms_level, span_active});
	end

	// Drive one request and hold it until the block takes it. The prediction is
	// made at the accepting edge, so request order matches answer order.
	task automatic send_request(logic [2:0] req, logic [1:0] sel, set_t t);
		set_t cut;
		req_type <= req;
		set_select <= sel;
		tally_count <= t.count[31:0];
		tally_minimum <= t.mn;
		tally_maximum <= t.mx;
		tally_clip_low <= t.clip_lo[31:0];
		tally_clip_high <= t.clip_hi[31:0];
		tally_square_sum <= t.sq_sum;
		in_valid <= 1'b1;
		cut = t;
		cut.count[63:32] = '0;
		cut.clip_lo[63:32] = '0;
		cut.clip_hi[63:32] = '0;
		do @(posedge clk); while (!in_ready);
		board.note_request(req, sel, cut);
		sent++;
	endtask

	task automatic pause_sender();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(posedge clk);
	endtask

	// Random tally; the range argument picks small, typical or full-range numbers.
	function automatic set_t random_tally(int range);
		set_t t;
		t = '0;
		case (range)
			0: begin
				t.count = 64'($urandom_range(1, 50));
				t.clip_lo = 64'($urandom_range(0, 5));
				t.clip_hi = 64'($urandom_range(0, 5));
				t.sq_sum = 64'($urandom_range(0, 100000));
			end
			1: begin
				t.count = 64'($urandom);
				t.clip_lo = 64'($urandom);
				t.clip_hi = 64'($urandom);
				t.sq_sum = {$urandom, $urandom};
			end
			default: begin
				t.count = 64'(32'hFFFF_FFFF - $urandom_range(0, 3));
				t.clip_lo = 64'(32'hFFFF_FFFF);
				t.clip_hi = 64'(32'hFFFF_FFFF - $urandom_range(0, 3));
				t.sq_sum = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
			end
		endcase
		if ($urandom_range(0, 15) == 0) t.count = '0;
		t.mn = 16'($urandom);
		t.mx = 16'($urandom);
		// Mostly well ordered tallies; a few stay inverted.
		if (t.mn > t.mx && $urandom_range(0, 7) != 0) begin
			t.mn = t.mn ^ t.mx;
			t.mx = t.mn ^ t.mx;
			t.mn = t.mn ^ t.mx;
		end
		return t;
	endfunction

	initial begin
		set_t        t;
		logic [2:0]  req;
		logic [1:0]  sel;
		int          burst;
		int          roll;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reads of an empty block, every request code, the unknown
		// codes, an ignored zero count, an inverted tally, and full-scale values
		// that drive the square sum to saturation.
		t = '0;
		send_request(REQ_READ, SEL_SESSION, t);
		send_request(REQ_READ, SEL_NONE, t);
		send_request(3'd5, SEL_SPAN, t);
		t = '{count: 1, clip_lo: 0, clip_hi: 0, sq_sum: 0, mn: 16'h0000, mx: 16'hFFFF};
		send_request(REQ_ADD, SEL_RECENT, t);
		send_request(REQ_OPEN, SEL_SPAN, t);
		send_request(REQ_OPEN, SEL_SPAN, t);
		t = '{count: 4, clip_lo: 1, clip_hi: 2, sq_sum: 400, mn: 16'd900, mx: 16'd10};
		send_request(REQ_ADD, SEL_SPAN, t);
		t.count = '0;
		send_request(REQ_ADD, SEL_RECENT, t);
		t = '{count: 32'hFFFF_FFFF, clip_lo: 32'hFFFF_FFFF, clip_hi: 32'hFFFF_FFFF,
			sq_sum: 64'hFFFF_FFFF_FFFF_FFFF, mn: 16'hFFFF, mx: 16'hFFFF};
		for (int i = 0; i < 4; i++) send_request(REQ_ADD, SEL_SESSION, t);
		t = '{count: 1, clip_lo: 0, clip_hi: 0, sq_sum: 64'hFFFF_FFFF_FFFF_FFFF,
			mn: 16'h5555, mx: 16'hAAAA};
		send_request(REQ_ADD, SEL_RECENT, t);
		send_request(REQ_CLOSE, SEL_SPAN, t);
		send_request(REQ_ADD, SEL_SPAN, t);
		send_request(3'd6, SEL_NONE, t);
		send_request(3'd7, SEL_SESSION, t);
		send_request(REQ_CLEAR, SEL_SESSION, t);
		send_request(REQ_READ, SEL_SPAN, t);
		pause_sender();

		// Random part: bursts of requests drawn at random (mostly adds, then opens,
		// closes, reads and clears) with random content, plus a share of unknown codes.
		while (sent < 950) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst; b++) begin
				roll = $urandom_range(0, 99);
				if (roll < 60) req = REQ_ADD;
				else if (roll < 70) req = REQ_OPEN;
				else if (roll < 78) req = REQ_CLOSE;
				else if (roll < 90) req = REQ_READ;
				else if (roll < 94) req = REQ_CLEAR;
				else req = 3'($urandom_range(5, 7));
				sel = ($urandom_range(0, 19) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
				roll = $urandom_range(0, 99);
				t = random_tally(roll < 60 ? 0 : (roll < 92 ? 1 : 2));
				send_request(req, sel, t);
			end
			pause_sender();
		end
		in_valid <= 1'b0;

		// Drain every outstanding answer, then let the clock run on before the summary.
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d requests, %0d answers checked, all request and selection codes",
			sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("signal_level_statistics_test: done, clean");
		else
			$display("signal_level_statistics_test: done, errors");
		$finish;
	end
endmodule

### files.f
rtl/sls_pkg.sv
rtl/signal_level_statistics.sv
tb/sv/signal_level_statistics_test.sv
